@@ rtl/dsic_pkg.sv @@
// Shared types, character codes and status codes of the decimal string checker.
package dsic_pkg;

	// Parser phase, one-hot encoded.
	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_REJECT = 4'b1000
	} phase_t;

	// Parser state carried from one character to the next.
	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic [63:0] mag;
		logic        sat;
	} parse_st_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
	} result_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NOT_INT  = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Saturation limits of the 64-bit magnitude.
	localparam logic [63:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

	// Largest magnitudes that still fit a 32-bit signed value.
	localparam logic [63:0] MAG_POS_MAX32 = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MAG_NEG_MAX32 = 64'h0000_0000_8000_0000;

	localparam parse_st_t PARSE_CLEAR = '{phase: PH_START, neg: 1'b0, mag: 64'd0, sat: 1'b0};

endpackage

@@ rtl/dsic_if.sv @@
// Handshake channel interfaces of the decimal string checker.
interface dsic_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source(output valid, output char_code, output last_char, input ready);
	modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface dsic_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] value;

	modport source(output valid, output status, output value, input ready);
	modport sink(input valid, input status, input value, output ready);
endinterface

interface dsic_cfg_if;
	logic valid;
	logic ready;
	logic check_overflow;

	modport source(output valid, output check_overflow, input ready);
	modport sink(input valid, input check_overflow, output ready);
endinterface

@@ rtl/dsic_step.sv @@
// Per-character parser update and end-of-string result formation.
module dsic_step (
	input  dsic_pkg::parse_st_t st,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	input  logic                check_overflow,
	output dsic_pkg::parse_st_t st_nxt,
	output dsic_pkg::result_t   res
);

	logic                is_digit;
	logic [3:0]          digit;
	logic [63:0]         limit;
	logic [67:0]         prod;
	logic [63:0]         acc_mag;
	logic                acc_sat;
	dsic_pkg::parse_st_t upd;
	logic                ovf;
	logic [31:0]         low32;

	// Decode the character.
	assign is_digit = (char_code >= dsic_pkg::CHAR_ZERO) && (char_code <= dsic_pkg::CHAR_NINE);
	assign digit    = char_code[3:0];

	// Times ten plus digit with saturation; the product exceeds the limit exactly
	// when the old magnitude is above (limit - digit) / 10.
	always_comb begin
		limit = st.neg ? dsic_pkg::MAG_NEG_LIMIT : dsic_pkg::MAG_POS_LIMIT;
		prod  = ({4'd0, st.mag} << 3) + ({4'd0, st.mag} << 1) + {64'd0, digit};
		if (st.sat) begin
			acc_mag = st.mag;
			acc_sat = 1'b1;
		end else if (prod > {4'd0, limit}) begin
			acc_mag = limit;
			acc_sat = 1'b1;
		end else begin
			acc_mag = prod[63:0];
			acc_sat = 1'b0;
		end
	end

	// Phase transitions.
	always_comb begin
		upd = st;
		case (st.phase)
			dsic_pkg::PH_START: begin
				if (char_code == dsic_pkg::CHAR_PLUS) begin
					upd.phase = dsic_pkg::PH_SIGN;
				end else if (char_code == dsic_pkg::CHAR_MINUS) begin
					upd.phase = dsic_pkg::PH_SIGN;
					upd.neg   = 1'b1;
				end else if (is_digit) begin
					upd.phase = dsic_pkg::PH_DIGITS;
					upd.mag   = acc_mag;
					upd.sat   = acc_sat;
				end else begin
					upd.phase = dsic_pkg::PH_REJECT;
				end
			end
			dsic_pkg::PH_SIGN, dsic_pkg::PH_DIGITS: begin
				if (is_digit) begin
					upd.phase = dsic_pkg::PH_DIGITS;
					upd.mag   = acc_mag;
					upd.sat   = acc_sat;
				end else begin
					upd.phase = dsic_pkg::PH_REJECT;
				end
			end
			default: begin
				upd.phase = dsic_pkg::PH_REJECT;
			end
		endcase
	end

	// Result from the updated state; the parser clears after the last character.
	always_comb begin
		ovf   = upd.sat || (upd.neg ? (upd.mag > dsic_pkg::MAG_NEG_MAX32)
		                            : (upd.mag > dsic_pkg::MAG_POS_MAX32));
		low32 = upd.neg ? (32'd0 - upd.mag[31:0]) : upd.mag[31:0];
		if (upd.phase != dsic_pkg::PH_DIGITS) begin
			res.status = dsic_pkg::STATUS_NOT_INT;
			res.value  = 32'sd0;
		end else if (check_overflow && ovf) begin
			res.status = dsic_pkg::STATUS_OVERFLOW;
			res.value  = 32'sd0;
		end else begin
			res.status = dsic_pkg::STATUS_OK;
			res.value  = signed'(low32);
		end
		st_nxt = last_char ? dsic_pkg::PARSE_CLEAR : upd;
	end

endmodule

@@ rtl/decimal_string_to_int_checker_unit.sv @@
// Top level of the decimal string to 32-bit integer checker.
// The block takes one character beat per clock cycle and returns one result beat when a
// beat marked as the last character has been parsed. A character is held in an input
// register, the parser state and the result are updated by combinational logic (one
// 68-bit times-ten-plus-digit add with a saturation compare), and the result sits in an
// output register, so a result beat is offered once its last character has passed the input register.
// The input stays open while a result waits; it stalls only when a last-character beat
// finds the output register still full. The check_overflow register resets to 1 and is
// written through the configuration channel, which is always ready.
module decimal_string_to_int_checker_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	dsic_char_if.sink            chars,
	dsic_result_if.source        results,
	dsic_cfg_if.sink             cfg
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;
	logic                valid_s2;
	dsic_pkg::result_t   res_s2;
	dsic_pkg::parse_st_t st_q;
	dsic_pkg::parse_st_t st_nxt;
	dsic_pkg::result_t   res_nxt;
	logic                chk_q;
	logic                adv;

	// The input register moves on unless a last character finds the result register blocked.
	assign adv         = valid_s1 && (!last_s1 || !valid_s2 || results.ready);
	assign chars.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= 1'b1;
		end else if (cfg.valid) begin
			chk_q <= cfg.check_overflow;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// Parser update.
	dsic_step u_step (
		.st             (st_q),
		.char_code      (char_s1),
		.last_char      (last_s1),
		.check_overflow (chk_q),
		.st_nxt         (st_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dsic_pkg::PARSE_CLEAR;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign results.valid  = valid_s2;
	assign results.status = res_s2.status;
	assign results.value  = res_s2.value;

`ifndef SYNTHESIS
	// After a last character the parser is back at its start.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q.phase == dsic_pkg::PH_START && st_q.mag == 64'd0
			&& !st_q.neg && !st_q.sat)
		else $error("parser not cleared after last character");

	// A saturated magnitude sits exactly at its limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.sat |-> (st_q.neg ? st_q.mag == dsic_pkg::MAG_NEG_LIMIT
		                       : st_q.mag == dsic_pkg::MAG_POS_LIMIT))
		else $error("saturated magnitude off its limit");

	// The start phase carries no sign and no magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == dsic_pkg::PH_START |-> st_q.mag == 64'd0 && !st_q.neg && !st_q.sat)
		else $error("start phase with leftover state");

	// A result beat never carries an unused status code, and non-OK results carry zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.status == dsic_pkg::STATUS_OK
			|| (res_s2.status == dsic_pkg::STATUS_NOT_INT && res_s2.value == 32'sd0)
			|| (res_s2.status == dsic_pkg::STATUS_OVERFLOW && res_s2.value == 32'sd0))
		else $error("malformed result beat");

	// A stalled result is not overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !results.ready |=> valid_s2 && $stable(res_s2))
		else $error("pending result lost");
`endif

endmodule
